FILE: hdl/cbcp_pkg.sv
// Shared types and constants of the class boundary cut point detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cbcp_pkg;

	localparam int VALUE_W = 32;
	localparam int LABEL_W = 8;
	localparam int TOL_W   = 31;
	localparam int CUT_W   = 17;

	localparam int MAX_ITEMS_DEF   = 65536;
	localparam int QUEUE_DEPTH_DEF = 4;

	// One queue entry holds every result caused by one sample.
	typedef struct packed {
		logic             two;
		logic [CUT_W-1:0] idx0;
		logic [CUT_W-1:0] idx1;
	} cbcp_entry_t;

	typedef struct packed {
		logic        push;
		cbcp_entry_t entry;
	} cbcp_qwr_t;

	typedef struct packed {
		logic        full;
		logic        nonempty;
		cbcp_entry_t head;
	} cbcp_qstat_t;

endpackage

`default_nettype wire

FILE: hdl/cbcp_if.sv
// Channel interfaces of the cut point detector: samples in, cut points out.
// Depends on cbcp_pkg.
`default_nettype none

interface cbcp_in_if
	import cbcp_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [LABEL_W-1:0] label;
	logic               last;

	modport source (output valid, value, label, last, input ready);
	modport sink (input valid, value, label, last, output ready);
endinterface

interface cbcp_out_if
	import cbcp_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [CUT_W-1:0] cut_index;
	logic             end_of_run;

	modport source (output valid, cut_index, end_of_run, input ready);
	modport sink (input valid, cut_index, end_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/cbcp_front.sv
// Front part: holds the tolerance register and the block state, classifies
// each sample and writes the cut points it causes into the queue. Uses cbcp_pkg.
`default_nettype none

module cbcp_front
	import cbcp_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [TOL_W-1:0]   cfg_wdata,
	input  wire logic               accept,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [LABEL_W-1:0] label,
	input  wire logic               last,
	output cbcp_qwr_t               qwr
);

	localparam int IDX_W = $clog2(MAX_ITEMS + 1);
	localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_ITEMS);

	logic [TOL_W-1:0]   tol_q;
	logic [IDX_W-1:0]   count_q;
	logic [VALUE_W-1:0] prev_q;
	logic [LABEL_W-1:0] blk_label_q;
	logic               blk_mixed_q;
	logic               first_q;
	logic [LABEL_W-1:0] ear_label_q;
	logic               ear_mixed_q;
	logic [IDX_W-1:0]   ear_bound_q;

	logic               start;
	logic signed [VALUE_W:0] diff;
	logic               joined;
	logic               close_now;
	logic               new_label;
	logic               blocks_differ;
	logic               emit_first;
	logic               emit_final;
	logic [IDX_W-1:0]   count_inc;

	assign start     = (count_q == '0);
	assign diff      = $signed({value[VALUE_W-1], value}) - $signed({prev_q[VALUE_W-1], prev_q});
	assign joined    = !start && (diff <= $signed({2'b00, tol_q}));
	assign close_now = !start && !joined;
	assign new_label = (label != blk_label_q);
	assign count_inc = (count_q == MaxIdx) ? count_q : count_q + 1'b1;

	// The block closing now (on a rise or on a final joining sample) is
	// compared with the earlier block; both cases report the earlier boundary.
	// A final joining sample with a new label makes its own block mixed first.
	assign blocks_differ = blk_mixed_q || ear_mixed_q || (blk_label_q != ear_label_q) ||
		(joined && new_label);
	assign emit_first    = !first_q && blocks_differ && (close_now || (last && joined));

	// The end check only fires when the final sample opened a block of its own:
	// after a joining close the two blocks are identical. The closed block is
	// then the earlier one, with its boundary at the current index.
	assign emit_final = last && close_now && (blk_mixed_q || new_label);

	always_comb begin
		qwr.push       = accept && (emit_first || emit_final);
		qwr.entry.two  = emit_first && emit_final;
		qwr.entry.idx0 = emit_first ? CUT_W'(ear_bound_q) : CUT_W'(count_q);
		qwr.entry.idx1 = CUT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			prev_q      <= '0;
			blk_label_q <= '0;
			blk_mixed_q <= 1'b0;
			first_q     <= 1'b1;
			ear_label_q <= '0;
			ear_mixed_q <= 1'b1;
			ear_bound_q <= '0;
		end else if (accept) begin
			if (last) begin
				count_q     <= '0;
				prev_q      <= '0;
				blk_label_q <= '0;
				blk_mixed_q <= 1'b0;
				first_q     <= 1'b1;
				ear_label_q <= '0;
				ear_mixed_q <= 1'b1;
				ear_bound_q <= '0;
			end else begin
				count_q <= count_inc;
				prev_q  <= value;
				if (start) begin
					blk_label_q <= label;
					blk_mixed_q <= 1'b0;
				end else if (joined) begin
					blk_mixed_q <= blk_mixed_q || new_label;
				end else begin
					ear_label_q <= blk_label_q;
					ear_mixed_q <= blk_mixed_q;
					ear_bound_q <= count_q;
					first_q     <= 1'b0;
					blk_label_q <= label;
					blk_mixed_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cbcp_queue.sv
// Short queue between the front and back parts; one entry per sample that
// causes results. Uses cbcp_pkg.
`default_nettype none

module cbcp_queue
	import cbcp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cbcp_qwr_t qwr,
	input  wire logic pop,
	output cbcp_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

	cbcp_entry_t      slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	always_comb begin
		qstat.full     = (fill_q == FullCnt);
		qstat.nonempty = (fill_q != '0);
		qstat.head     = slots_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			slots_q[wr_ptr_q] <= qwr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({qwr.push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cbcp_back.sv
// Back part: takes queue entries and sends their cut points one transfer at
// a time, marking the last one of each sample. Uses cbcp_pkg and cbcp_if.
`default_nettype none

module cbcp_back
	import cbcp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cbcp_qstat_t qstat,
	output logic       pop,
	cbcp_out_if.source cuts
);

	logic second_q;
	logic xfer;

	assign xfer            = cuts.valid && cuts.ready;
	assign cuts.valid      = qstat.nonempty;
	assign cuts.cut_index  = second_q ? qstat.head.idx1 : qstat.head.idx0;
	assign cuts.end_of_run = second_q || !qstat.head.two;
	assign pop             = xfer && cuts.end_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (xfer) begin
			second_q <= !cuts.end_of_run;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/class_boundary_cut_points.sv
// Top level of the class boundary cut point detector: front, queue and back.
// Depends on cbcp_pkg, cbcp_if, cbcp_front, cbcp_queue and cbcp_back.
//
// Samples arrive sorted by value, each with a class label, and the block
// groups neighbors that rise by at most the tolerance register into blocks.
// When a block closes it is compared with the one before it, and the start
// index of the closing block goes out as a candidate cut point when either
// is mixed or their labels differ; a sample can cause zero, one or two cut
// points, the last of them marked by end_of_run. A sample is accepted every
// cycle while the queue has room: the front classifies each sample
// combinationally, and the back sends one cut point per cycle while the
// output is ready; the QUEUE_DEPTH entry queue absorbs a sample with two.
// Indices saturate at MAX_ITEMS. Write tolerance only while the block is idle.
`default_nettype none

module class_boundary_cut_points
	import cbcp_pkg::*;
#(
	parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [TOL_W-1:0] cfg_wdata,
	cbcp_in_if.sink               samples,
	cbcp_out_if.source            cuts
);

	cbcp_qwr_t   qwr;
	cbcp_qstat_t qstat;
	logic        pop;
	logic        accept;

	assign samples.ready = !qstat.full;
	assign accept        = samples.valid && samples.ready;

	cbcp_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.value    (samples.value),
		.label    (samples.label),
		.last     (samples.last),
		.qwr      (qwr)
	);

	cbcp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.qwr   (qwr),
		.pop   (pop),
		.qstat (qstat)
	);

	cbcp_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.pop   (pop),
		.cuts  (cuts)
	);

	// An entry is only written when the queue has room for it.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.push |-> (!qstat.full || pop))
		else $error("queue written while full");

	// After the first of two cut points the second is offered at once.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cuts.valid && cuts.ready && !cuts.end_of_run) |=> cuts.valid)
		else $error("second cut point missing");

	// A transfer that ends a sample's results retires its queue entry.
	a_pop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cuts.valid && cuts.ready && cuts.end_of_run) |-> pop)
		else $error("queue entry not retired");

endmodule

`default_nettype wire
